// File: hdl/sve_pkg.sv
// ----------------------------------------------------------------------------
// sve_pkg
// Types and constants shared by the signed variable-length encoder stages.
// ----------------------------------------------------------------------------
package sve_pkg;

  typedef enum logic [2:0] {
    FORM_SINGLE,
    FORM_C1,
    FORM_C2,
    FORM_C3,
    FORM_LONG
  } form_t;

  // compare flags found in the first stage
  typedef struct packed {
    logic single;
    logic c1;
    logic c2;
    logic c3;
  } flags_t;

  // chosen encoding and trailing byte count
  typedef struct packed {
    form_t      form;
    logic [3:0] nbytes;
  } cls_t;

  localparam logic [7:0] C1_BIAS   = 8'd52;
  localparam logic [7:0] C2_BIAS   = 8'd88;
  localparam logic [7:0] C3_BIAS   = 8'd112;
  localparam logic [7:0] LONG_BIAS = 8'd127;

  localparam logic [55:0] C1_LIMIT = 56'd20;
  localparam logic [47:0] C2_LIMIT = 48'd16;
  localparam logic [39:0] C3_LIMIT = 40'd8;
  localparam logic [63:0] POS_MAX  = 64'd127;
  localparam logic [63:0] NEG_MAX  = 64'd31;

endpackage

// File: hdl/sve_prep.sv
// ----------------------------------------------------------------------------
// sve_prep
// Stage 1: magnitude word and compare flags for the short forms.
// ----------------------------------------------------------------------------
module sve_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         u,
  output logic [63:0]         m,
  output sve_pkg::flags_t     flags
);
  import sve_pkg::*;

  logic [63:0] m_in;
  flags_t      flags_in;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    m_in = value[63] ? ~value : value;
    flags_in.single = value[63] ? (m_in <= NEG_MAX) : (m_in <= POS_MAX);
    flags_in.c1 = m_in[63:8] < C1_LIMIT;
    flags_in.c2 = m_in[63:16] < C2_LIMIT;
    flags_in.c3 = m_in[63:24] < C3_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      u     <= value;
      m     <= m_in;
      flags <= flags_in;
    end
  end

endmodule

// File: hdl/sve_classify.sv
// ----------------------------------------------------------------------------
// sve_classify
// Stage 2: picks the encoding form and the number of trailing bytes.
// ----------------------------------------------------------------------------
module sve_classify (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         u_in,
  input  logic [63:0]         m,
  input  sve_pkg::flags_t     flags,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         u,
  output sve_pkg::cls_t       cls
);
  import sve_pkg::*;

  cls_t cls_in;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    cls_in.form   = FORM_LONG;
    cls_in.nbytes = 4'd8;
    if (flags.single) begin
      cls_in.form   = FORM_SINGLE;
      cls_in.nbytes = 4'd0;
    end else if (flags.c1) begin
      cls_in.form   = FORM_C1;
      cls_in.nbytes = 4'd1;
    end else if (flags.c2) begin
      cls_in.form   = FORM_C2;
      cls_in.nbytes = 4'd2;
    end else if (flags.c3) begin
      cls_in.form   = FORM_C3;
      cls_in.nbytes = 4'd3;
    end else if (m[63:31] == '0) begin
      cls_in.nbytes = 4'd4;
    end else if (m[63:39] == '0) begin
      cls_in.nbytes = 4'd5;
    end else if (m[63:47] == '0) begin
      cls_in.nbytes = 4'd6;
    end else if (m[63:55] == '0) begin
      cls_in.nbytes = 4'd7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      u   <= u_in;
      cls <= cls_in;
    end
  end

endmodule

// File: hdl/sve_format.sv
// ----------------------------------------------------------------------------
// sve_format
// Stage 3: builds the header byte and left-aligns the trailing bytes.
// ----------------------------------------------------------------------------
module sve_format (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         u,
  input  sve_pkg::cls_t       cls,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          header,
  output logic [3:0]          nbytes,
  output logic [63:0]         data
);
  import sve_pkg::*;

  logic [7:0]  header_in;
  logic [5:0]  sh;
  logic [63:0] data_in;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    case (cls.form)
      FORM_SINGLE: header_in = u[7:0];
      FORM_C1:     header_in = u[15:8] - C1_BIAS;
      FORM_C2:     header_in = u[23:16] - C2_BIAS;
      FORM_C3:     header_in = u[31:24] - C3_BIAS;
      FORM_LONG:   header_in = {4'd0, cls.nbytes} + LONG_BIAS;
      default:     header_in = u[7:0];
    endcase
    // first trailing byte ends up in bits 63:56
    sh      = {3'(4'd8 - cls.nbytes), 3'b000};
    data_in = u << sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      header <= header_in;
      nbytes <= cls.nbytes;
      data   <= data_in;
    end
  end

endmodule

// File: hdl/sve_serial.sv
// ----------------------------------------------------------------------------
// sve_serial
// Output stage: header, then trailing bytes, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module sve_serial (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  header,
  input  logic [3:0]  nbytes,
  input  logic [63:0] data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last
);
  logic [63:0] data;
  logic [3:0]  cnt;
  logic        taken;

  assign taken    = out_valid && !out_stall;
  // next item loads as the final byte of the current one leaves
  assign in_ready = !out_valid || (taken && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        cnt <= nbytes;
      end
    end else if (taken) begin
      cnt <= cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_byte <= header;
      last     <= (nbytes == 4'd0);
      data     <= data_in;
    end else if (taken && !last) begin
      out_byte <= data[63:56];
      last     <= (cnt == 4'd1);
      data     <= {data[55:0], 8'd0};
    end
  end

endmodule

// File: hdl/signed_vlong_encoder.sv
// ----------------------------------------------------------------------------
// signed_vlong_encoder
// Variable-length encoder for signed 64-bit values, byte-wide output.
// ----------------------------------------------------------------------------
// Each accepted value comes out as 1 to 9 bytes, header first, with last
// set on the final byte. Three register stages (compare flags, form
// select, header build and byte alignment) feed a byte serializer, so the
// first byte of a value reaches the output through those three registers
// and the serializer's output register. The serializer sends one byte per
// cycle while out_stall is low, and sends a header and then n trailing
// bytes per value, n being its trailing byte count (0 to 8): values in
// -32..127 are a lone header byte, the widest values nine bytes. The
// stages take a new value every cycle until the serializer backs them up;
// stall on either side drops and repeats nothing.
module signed_vlong_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last
);
  import sve_pkg::*;

  logic        s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
  logic        in_ready;
  logic [63:0] s1_u, s1_m, s2_u, s3_data;
  flags_t      s1_flags;
  cls_t        s2_cls;
  logic [7:0]  s3_header;
  logic [3:0]  s3_nbytes;

  assign in_stall = !in_ready;

  sve_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .u         (s1_u),
    .m         (s1_m),
    .flags     (s1_flags)
  );

  sve_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .u_in      (s1_u),
    .m         (s1_m),
    .flags     (s1_flags),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .u         (s2_u),
    .cls       (s2_cls)
  );

  sve_format u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .u         (s2_u),
    .cls       (s2_cls),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .header    (s3_header),
    .nbytes    (s3_nbytes),
    .data      (s3_data)
  );

  sve_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .header    (s3_header),
    .nbytes    (s3_nbytes),
    .data_in   (s3_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for signed_vlong_encoder: an encoding predictor feeds a
// queue of expected bytes; each byte the block sends is checked against it.
// ----------------------------------------------------------------------------
module tb;
  import sve_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last_flag;
  } enc_byte_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [63:0] value     = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  enc_byte_t   enc_q[$];
  enc_byte_t   head;
  int          errors    = 0;
  int          n_items   = 0;
  int          n_bytes   = 0;
  int          form_cnt[5];

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_req      = 0;
  int          hold_ack      = 0;
  int          hold_left     = 0;

  signed_vlong_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("TEST FAILED");
    $finish;
  end

  // Works out the byte run for one value and queues it.
  task automatic push_encoding(input logic [63:0] v);
    logic        neg;
    logic [63:0] m;
    logic [63:0] top;
    logic [7:0]  hdr;
    int          nb;
    int          bits;
    enc_byte_t   e;
    neg = v[63];
    m   = neg ? ~v : v;
    if ((!neg && v <= 64'd127) || (neg && m <= 64'd31)) begin
      e.data = v[7:0];
      e.last_flag = 1'b1;
      enc_q.push_back(e);
      form_cnt[FORM_SINGLE]++;
      return;
    end
    if ((m >> 8) < 64'd20) begin
      top = m >> 8;
      hdr = (neg ? ~top[7:0] : top[7:0]) - 8'd52;
      nb  = 1;
      form_cnt[FORM_C1]++;
    end else if ((m >> 16) < 64'd16) begin
      top = m >> 16;
      hdr = (neg ? ~top[7:0] : top[7:0]) - 8'd88;
      nb  = 2;
      form_cnt[FORM_C2]++;
    end else if ((m >> 24) < 64'd8) begin
      top = m >> 24;
      hdr = (neg ? ~top[7:0] : top[7:0]) - 8'd112;
      nb  = 3;
      form_cnt[FORM_C3]++;
    end else begin
      bits = 0;
      for (int i = 63; i >= 0; i--) begin
        if (m[i] && bits == 0) bits = i + 1;
      end
      nb  = bits / 8 + 1;
      hdr = 8'(nb + 127);  // len - 129, low eight bits
      form_cnt[FORM_LONG]++;
    end
    e.data = hdr;
    e.last_flag = 1'b0;
    enc_q.push_back(e);
    for (int i = 0; i < nb; i++) begin
      top = v >> (8 * (nb - 1 - i));
      e.data = top[7:0];
      e.last_flag = (i == nb - 1);
      enc_q.push_back(e);
    end
  endtask

  // Receiver side: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_ack  <= hold_req;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Output check first, then queue the item accepted on this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_bytes++;
        if (enc_q.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual %h last %b",
                   $time, out_byte, last);
          errors++;
        end else begin
          head = enc_q.pop_front();
          if (out_byte !== head.data) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, head.data, out_byte);
            errors++;
          end
          if (last !== head.last_flag) begin
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, head.last_flag, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        push_encoding(value);
        n_items++;
      end
    end
  end

  // Leaves valid high after acceptance; the next call decides whether to lower it.
  task automatic send_item(input logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (enc_q.size() != 0) @(posedge clk);
  endtask

  // Picks a magnitude with a random top bit so every form is reached.
  function automatic logic [63:0] rand_value();
    logic [63:0] r;
    logic [63:0] m;
    int          k;
    r = {$urandom, $urandom};
    if ($urandom_range(99) < 20) return r;
    k = $urandom_range(62, 0);
    m = (r & ((64'd1 << k) - 64'd1)) | (64'd1 << k);
    if ($urandom_range(1)) m = ~m;
    return m;
  endfunction

  task automatic test_boundaries();
    logic [63:0] pts[$];
    pts = '{64'd0, 64'd127, 64'd128, -64'sd32, -64'sd33, -64'sd1,
            64'd5119, 64'd5120, -64'sd5120, -64'sd5121,
            64'd1048575, 64'd1048576, -64'sd1048576, -64'sd1048577,
            64'd134217727, 64'd134217728, -64'sd134217728, -64'sd134217729,
            64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
            64'h0000_0080_0000_0000, 64'h0000_8000_0000_0000,
            64'h0080_0000_0000_0000,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};
    send_idle_pct = 0;
    stall_pct <= 0;
    foreach (pts[i]) send_item(pts[i]);
    go_idle();
    wait_drain();
  endtask

  task automatic test_random(input int n, input int s_idle, input int r_stall);
    send_idle_pct = s_idle;
    stall_pct <= r_stall;
    repeat (n) send_item(rand_value());
    go_idle();
    wait_drain();
  endtask

  // Receiver holds off long enough for the pipeline to fill and back up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct <= 30;
    hold_req++;
    repeat (40) send_item(rand_value());
    go_idle();
    wait_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_boundaries();
    test_random(55, 0, 0);
    test_random(55, 58, 0);
    test_random(55, 0, 58);
    test_random(55, 18, 18);
    test_backpressure();
    repeat (20) @(posedge clk);
    $display("Ran %0d values, %0d bytes checked; boundary, random, idle and stall phases.",
             n_items, n_bytes);
    $display("Forms: single %0d, c1 %0d, c2 %0d, c3 %0d, long %0d; errors %0d",
             form_cnt[FORM_SINGLE], form_cnt[FORM_C1], form_cnt[FORM_C2],
             form_cnt[FORM_C3], form_cnt[FORM_LONG], errors);
    if (errors == 0 && enc_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
